>>> src/tkr_pkg.sv
package tkr_pkg;

  localparam int unsigned ActionW = 3;
  localparam int unsigned KeyW    = 16;
  localparam int unsigned FlagsW  = 32;
  localparam int unsigned KindW   = 8;
  localparam int unsigned TagW    = 32;
  localparam int unsigned SeqW    = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ActionW-1:0] ACT_DOWN     = 3'd0;
  localparam logic [ActionW-1:0] ACT_UP       = 3'd1;
  localparam logic [ActionW-1:0] ACT_MODIFIER = 3'd2;
  localparam logic [ActionW-1:0] ACT_OTHER    = 3'd3;
  localparam logic [ActionW-1:0] ACT_TICK     = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_INITIAL_DELAY   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_REPEAT_INTERVAL = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_NO_KEY_CODE     = 2'd2;

  localparam logic [CfgW-1:0] INITIAL_DELAY_RST   = 16'd500;
  localparam logic [CfgW-1:0] REPEAT_INTERVAL_RST = 16'd83;
  localparam logic [CfgW-1:0] NO_KEY_CODE_RST     = 16'hFFFF;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [KeyW-1:0]    key_code;
    logic [FlagsW-1:0]  modifier_flags;
    logic [KindW-1:0]   keyboard_kind;
    logic [TagW-1:0]    source_tag;
  } tkr_in_t;

  typedef struct packed {
    logic [KeyW-1:0]   out_key_code;
    logic [FlagsW-1:0] out_flags;
    logic [KindW-1:0]  out_keyboard_kind;
    logic [TagW-1:0]   out_tag;
    logic              is_repeat;
    logic [SeqW-1:0]   sequence_number;
  } tkr_out_t;

endpackage

>>> src/typematic_key_repeat.sv
// Keyboard auto-repeat generator. Items are key events or one-millisecond
// ticks; a key down arms repeat for that key, and each tick counts down
// until one repeated key-down item is emitted, then the repeat interval
// reloads. Every item passes through an input register and a single pass of
// compare/decrement logic, and a firing tick loads an output register, so one
// item is accepted per cycle; the only limit is the output register, which
// stalls the input when it holds an untaken result. Configuration writes take
// effect on the next clock edge and should be made with no item in flight.
module typematic_key_repeat (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tkr_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tkr_pkg::CfgW-1:0]      cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tkr_pkg::tkr_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tkr_pkg::tkr_out_t             out_data
);
  import tkr_pkg::*;

  logic [CfgW-1:0]   initial_delay_r, repeat_interval_r, no_key_code_r;

  logic              in_valid_r;
  tkr_in_t           in_data_r;

  logic              repeating_r, repeating_nxt;
  logic [KeyW-1:0]   held_key_r, held_key_nxt;
  logic [FlagsW-1:0] held_flags_r, held_flags_nxt;
  logic [KindW-1:0]  held_kind_r, held_kind_nxt;
  logic [TagW-1:0]   held_tag_r, held_tag_nxt;
  logic [CfgW-1:0]   countdown_r, countdown_nxt;
  logic [SeqW-1:0]   seq_r, seq_nxt;

  logic              out_valid_r;
  tkr_out_t          out_data_r, out_data_nxt;

  logic proc, is_tick, ignored, fire;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_delay_r   <= INITIAL_DELAY_RST;
      repeat_interval_r <= REPEAT_INTERVAL_RST;
      no_key_code_r     <= NO_KEY_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INITIAL_DELAY:   initial_delay_r   <= cfg_wdata;
        REG_REPEAT_INTERVAL: repeat_interval_r <= cfg_wdata;
        REG_NO_KEY_CODE:     no_key_code_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // the input register moves on whenever the output register is free or drains
  assign proc     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  assign is_tick = (in_data_r.action == ACT_TICK);
  assign ignored = !is_tick && (in_data_r.key_code == no_key_code_r);
  assign fire    = is_tick && repeating_r && (countdown_r <= CfgW'(1));

  always_comb begin
    repeating_nxt  = repeating_r;
    held_key_nxt   = held_key_r;
    held_flags_nxt = held_flags_r;
    held_kind_nxt  = held_kind_r;
    held_tag_nxt   = held_tag_r;
    countdown_nxt  = countdown_r;
    seq_nxt        = seq_r;
    if (is_tick) begin
      if (fire) begin
        countdown_nxt = repeat_interval_r;
      end else if (repeating_r) begin
        countdown_nxt = countdown_r - CfgW'(1);
      end
    end else if (!ignored) begin
      case (in_data_r.action)
        ACT_DOWN: begin
          held_key_nxt   = in_data_r.key_code;
          held_flags_nxt = in_data_r.modifier_flags;
          held_kind_nxt  = in_data_r.keyboard_kind;
          held_tag_nxt   = in_data_r.source_tag;
          countdown_nxt  = initial_delay_r;
          repeating_nxt  = 1'b1;
          seq_nxt        = seq_r + SeqW'(2);
        end
        ACT_UP: begin
          if (repeating_r && in_data_r.key_code == held_key_r) begin
            repeating_nxt = 1'b0;
            seq_nxt       = seq_r + SeqW'(1);
          end
        end
        default: begin
          // modifier change, other event, undefined codes
          repeating_nxt = 1'b0;
          seq_nxt       = seq_r + SeqW'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeating_r  <= 1'b0;
      held_key_r   <= '0;
      held_flags_r <= '0;
      held_kind_r  <= '0;
      held_tag_r   <= '0;
      countdown_r  <= '0;
      seq_r        <= '0;
    end else if (proc) begin
      repeating_r  <= repeating_nxt;
      held_key_r   <= held_key_nxt;
      held_flags_r <= held_flags_nxt;
      held_kind_r  <= held_kind_nxt;
      held_tag_r   <= held_tag_nxt;
      countdown_r  <= countdown_nxt;
      seq_r        <= seq_nxt;
    end
  end

  always_comb begin
    out_data_nxt.out_key_code      = held_key_r;
    out_data_nxt.out_flags         = held_flags_r;
    out_data_nxt.out_keyboard_kind = held_kind_r;
    out_data_nxt.out_tag           = held_tag_r;
    out_data_nxt.is_repeat         = 1'b1;
    out_data_nxt.sequence_number   = seq_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_tick_keeps_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && is_tick) |=> (seq_r == $past(seq_r)))
    else $error("tick changed sequence counter");

  a_down_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && !ignored && in_data_r.action == ACT_DOWN) |=>
      (repeating_r && countdown_r == $past(initial_delay_r)))
    else $error("key down did not arm repeat");

  a_fire_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && fire) |=>
      (out_valid_r && out_data_r.sequence_number == $past(seq_r)
       && countdown_r == $past(repeat_interval_r)))
    else $error("fired tick did not emit item");

  a_fire_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && fire) |-> repeating_r)
    else $error("fire while idle");

endmodule

>>> tb/typematic_key_repeat_checker.sv
module typematic_key_repeat_checker
  import tkr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  tkr_in_t            in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  tkr_out_t           out_data,
  output int                 fail_count,
  output int                 pending
);

  logic [CfgW-1:0]   delay_ms;
  logic [CfgW-1:0]   interval_ms;
  logic [CfgW-1:0]   ignore_key;
  logic              armed;
  logic [KeyW-1:0]   held_key;
  logic [FlagsW-1:0] held_flags;
  logic [KindW-1:0]  held_kind;
  logic [TagW-1:0]   held_tag;
  logic [CfgW-1:0]   countdown;
  logic [SeqW-1:0]   seq_count;
  tkr_out_t          repeats_due[$];
  int                reported;

  task automatic advance_typematic(input tkr_in_t ev);
    tkr_out_t rep;
    if (ev.action == ACT_TICK) begin
      if (armed) begin
        if (countdown > 1) begin
          countdown = countdown - 1'b1;
        end else begin
          countdown = interval_ms;
          rep.out_key_code      = held_key;
          rep.out_flags         = held_flags;
          rep.out_keyboard_kind = held_kind;
          rep.out_tag           = held_tag;
          rep.is_repeat         = 1'b1;
          rep.sequence_number   = seq_count;
          repeats_due = {repeats_due, rep};
        end
      end
    end else if (ev.key_code != ignore_key) begin
      if (ev.action == ACT_DOWN) begin
        // cancel, then arm: the counter moves twice
        seq_count  = seq_count + SeqW'(2);
        held_key   = ev.key_code;
        held_flags = ev.modifier_flags;
        held_kind  = ev.keyboard_kind;
        held_tag   = ev.source_tag;
        countdown  = delay_ms;
        armed      = 1'b1;
      end else if (ev.action == ACT_UP) begin
        if (armed && ev.key_code == held_key) begin
          armed     = 1'b0;
          seq_count = seq_count + 1'b1;
        end
      end else begin
        armed     = 1'b0;
        seq_count = seq_count + 1'b1;
      end
    end
  endtask

  task automatic check_repeat(input tkr_out_t got);
    tkr_out_t want;
    logic     bad;
    if (repeats_due.size() == 0) begin
      fail_count++;
      if (reported < 10) begin
        $display("unexpected repeat item: key %h flags %h kind %h tag %h rep %b seq %h",
                 got.out_key_code, got.out_flags, got.out_keyboard_kind, got.out_tag,
                 got.is_repeat, got.sequence_number);
      end
      reported++;
    end else begin
      want = repeats_due.pop_front();
      bad = (got.out_key_code !== want.out_key_code) ||
            (got.out_flags !== want.out_flags) ||
            (got.out_keyboard_kind !== want.out_keyboard_kind) ||
            (got.out_tag !== want.out_tag) ||
            (got.is_repeat !== want.is_repeat) ||
            (got.sequence_number !== want.sequence_number);
      if (bad) begin
        fail_count++;
        if (reported < 10) begin
          $display("repeat mismatch: want key %h flags %h kind %h tag %h rep %b seq %h",
                   want.out_key_code, want.out_flags, want.out_keyboard_kind,
                   want.out_tag, want.is_repeat, want.sequence_number);
          $display("                  got key %h flags %h kind %h tag %h rep %b seq %h",
                   got.out_key_code, got.out_flags, got.out_keyboard_kind,
                   got.out_tag, got.is_repeat, got.sequence_number);
        end
        reported++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      delay_ms    = INITIAL_DELAY_RST;
      interval_ms = REPEAT_INTERVAL_RST;
      ignore_key  = NO_KEY_CODE_RST;
      armed       = 1'b0;
      held_key    = '0;
      held_flags  = '0;
      held_kind   = '0;
      held_tag    = '0;
      countdown   = '0;
      seq_count   = '0;
      fail_count  = 0;
      reported    = 0;
      repeats_due.delete();
    end else begin
      // result first: it can never come from an item taken at this same edge
      if (out_valid && !out_stall) begin
        check_repeat(out_data);
      end
      if (in_valid && !in_stall) begin
        advance_typematic(in_data);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_INITIAL_DELAY:   delay_ms    = cfg_wdata;
          REG_REPEAT_INTERVAL: interval_ms = cfg_wdata;
          REG_NO_KEY_CODE:     ignore_key  = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = repeats_due.size();
  end

endmodule

>>> tb/typematic_key_repeat_test.sv
module typematic_key_repeat_test;
  import tkr_pkg::*;

  localparam int IdleLimit = 2000;
  localparam logic [ActionW-1:0] ACT_RESERVED_LO = 3'd5;
  localparam logic [ActionW-1:0] ACT_RESERVED_HI = 3'd7;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = REG_INITIAL_DELAY;
  logic [CfgW-1:0]    cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  tkr_in_t            in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  tkr_out_t           out_data;

  int check_failures;
  int check_pending;

  int              burst_left   = 0;
  int              stall_left   = 0;
  int              stall_pct    = 0;
  int              quiet_cycles = 0;
  logic [KeyW-1:0] no_key       = NO_KEY_CODE_RST;
  logic [KeyW-1:0] last_down    = '0;
  logic [KeyW-1:0] key_pool[4];

  typematic_key_repeat dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  typematic_key_repeat_checker repeat_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (check_failures),
    .pending    (check_pending)
  );

  always #5 clk = ~clk;

  // receiver: segments of random length, each with its own stall density
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(1, 64);
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 50;
        default: stall_pct = 90;
      endcase
    end else begin
      stall_left--;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    while (quiet_cycles < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic tkr_in_t make_event(input logic [ActionW-1:0] action,
                                         input logic [KeyW-1:0]    key,
                                         input logic [FlagsW-1:0]  flags,
                                         input logic [KindW-1:0]   kind,
                                         input logic [TagW-1:0]    tag);
    tkr_in_t ev;
    ev.action         = action;
    ev.key_code       = key;
    ev.modifier_flags = flags;
    ev.keyboard_kind  = kind;
    ev.source_tag     = tag;
    return ev;
  endfunction

  function automatic tkr_in_t tick_event();
    return make_event(ACT_TICK, KeyW'($urandom), $urandom, KindW'($urandom), $urandom);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input tkr_in_t item);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (check_pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_timing(input logic [CfgW-1:0] delay, input logic [CfgW-1:0] interval,
                            input logic [CfgW-1:0] nokey);
    drain();
    // items that produce nothing may still be in flight
    repeat (4) @(negedge clk);
    write_reg(REG_INITIAL_DELAY, delay);
    write_reg(REG_REPEAT_INTERVAL, interval);
    write_reg(REG_NO_KEY_CODE, nokey);
    no_key     = nokey;
    burst_left = 0;
  endtask

  function automatic tkr_in_t random_event();
    tkr_in_t ev;
    int      pick;
    ev = make_event(ACT_TICK, '0, $urandom, KindW'($urandom_range(0, 255)), $urandom);
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      ev.key_code = key_pool[$urandom_range(0, 3)];
    end else if (pick < 7) begin
      ev.key_code = last_down;
    end else if (pick < 8) begin
      ev.key_code = no_key;
    end else begin
      ev.key_code = KeyW'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      ev.action = ACT_TICK;
    end else if (pick < 70) begin
      ev.action = ACT_DOWN;
    end else if (pick < 85) begin
      ev.action = ACT_UP;
      if ($urandom_range(0, 3) != 0) ev.key_code = last_down;
    end else if (pick < 90) begin
      ev.action = ACT_MODIFIER;
    end else if (pick < 95) begin
      ev.action = ACT_OTHER;
    end else begin
      ev.action = ActionW'($urandom_range(ACT_RESERVED_LO, ACT_RESERVED_HI));
    end
    return ev;
  endfunction

  task automatic run_phase(input logic [CfgW-1:0] delay, input logic [CfgW-1:0] interval,
                           input logic [CfgW-1:0] nokey, input int count);
    tkr_in_t ev;
    set_timing(delay, interval, nokey);
    foreach (key_pool[i]) key_pool[i] = KeyW'($urandom);
    repeat (count) begin
      ev = random_event();
      if (ev.action == ACT_DOWN && ev.key_code != no_key) last_down = ev.key_code;
      send_item(ev);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset timing: idle tick, ignored key, arm with the long default delay
    send_item(tick_event());
    send_item(make_event(ACT_DOWN, 16'hFFFF, '1, '1, '1));
    send_item(make_event(ACT_UP, 16'hFFFF, '0, '0, '0));
    send_item(make_event(ACT_DOWN, 16'h0000, '0, '0, '0));
    send_item(tick_event());

    set_timing(16'd2, 16'd1, 16'h0000);
    send_item(make_event(ACT_DOWN, 16'hFFFE, '1, '1, '1));
    repeat (3) send_item(tick_event());
    send_item(make_event(ACT_UP, 16'h1234, '0, '0, '0));
    send_item(tick_event());
    send_item(make_event(ACT_UP, 16'h0000, '0, '0, '0));
    send_item(make_event(ACT_MODIFIER, 16'h0000, '0, '0, '0));
    send_item(tick_event());
    send_item(make_event(ACT_UP, 16'hFFFE, '0, '0, '0));
    send_item(tick_event());
    send_item(make_event(ACT_UP, 16'hFFFE, '0, '0, '0));
    send_item(make_event(ACT_DOWN, 16'h8000, 32'hA5A5A5A5, 8'h5A, 32'h5A5A5A5A));
    send_item(make_event(ACT_MODIFIER, 16'h0001, '0, '0, '0));
    send_item(make_event(ACT_DOWN, 16'h7FFF, 32'h5A5A5A5A, 8'hA5, 32'hA5A5A5A5));
    send_item(make_event(ACT_OTHER, 16'h0002, '0, '0, '0));
    send_item(make_event(ACT_DOWN, 16'h0001, '0, '0, '0));
    send_item(make_event(ACT_RESERVED_LO, 16'h0001, '0, '0, '0));
    send_item(make_event(ACT_DOWN, 16'h0003, '1, '0, '1));
    send_item(make_event(ACT_RESERVED_HI, 16'h0003, '0, '0, '0));

    // zero delay and interval fire on every tick
    set_timing(16'd0, 16'd0, NO_KEY_CODE_RST);
    send_item(make_event(ACT_DOWN, 16'h4242, 32'h0000FFFF, 8'h0F, 32'hFFFF0000));
    repeat (2) send_item(tick_event());

    run_phase(16'd3, 16'd2, NO_KEY_CODE_RST, 125);
    run_phase('0, '0, '0, 125);
    run_phase('1, '1, CfgW'($urandom), 100);
    run_phase(16'd1, '1, CfgW'($urandom), 100);
    repeat (4) begin
      run_phase(CfgW'($urandom_range(0, 20)), CfgW'($urandom_range(0, 10)),
                ($urandom_range(0, 1) == 0) ? NO_KEY_CODE_RST : CfgW'($urandom), 140);
    end

    drain();
    repeat (8) @(negedge clk);
    if (check_failures == 0 && check_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
src/tkr_pkg.sv
src/typematic_key_repeat.sv
tb/typematic_key_repeat_checker.sv
tb/typematic_key_repeat_test.sv
